/* hw/rtl/sobel_gradient_magnitude_3x3_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Sobel gradient core
// Concurrent checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef SOBEL_GRADIENT_MAGNITUDE_3X3_CORE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_3X3_CORE_MACROS_SVH

// same-cycle implication
`define SGM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgm assertion failed");

// next-cycle implication
`define SGM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgm assertion failed");

`endif

/* hw/rtl/sgm_pkg.sv */
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants, types and helpers of the Sobel gradient core.
// ----------------------------------------------------------------------------
package sgm_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = CFG_W'(640);
	localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = CFG_W'(480);
	localparam logic [CFG_W-1:0] MIN_DIM          = CFG_W'(3);

	// right column of the window: both halves of a line store entry and the new pixel
	typedef struct packed {
		logic [PIX_W-1:0] top;
		logic [PIX_W-1:0] mid;
		logic [PIX_W-1:0] bot;
	} taps_t;

	function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
		input logic [CFG_W-1:0] hi);
		logic [CFG_W-1:0] r;
		if (v < MIN_DIM)
			r = MIN_DIM;
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

endpackage

/* hw/rtl/sgm_ram.sv */
// ----------------------------------------------------------------------------
// sgm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sgm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

/* hw/rtl/sgm_window.sv */
// ----------------------------------------------------------------------------
// sgm_window
// 3x3 window columns and the Sobel magnitude datapath.
// ----------------------------------------------------------------------------
module sgm_window (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        shift,
	input  sgm_pkg::taps_t              taps,
	output logic [sgm_pkg::PIX_W-1:0]   magnitude
);

	localparam int SW = sgm_pkg::PIX_W + 3;

	// [0..2] column c-2 (top, mid, bottom), [3..5] column c-1
	logic [sgm_pkg::PIX_W-1:0] win_q [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				win_q[i] <= '0;
		end else if (shift) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= taps.top;
			win_q[4] <= taps.mid;
			win_q[5] <= taps.bot;
		end
	end

	function automatic logic signed [SW-1:0] sx(input logic [sgm_pkg::PIX_W-1:0] v);
		return $signed({3'b000, v});
	endfunction

	logic signed [SW-1:0] gx, gy;
	logic signed [SW-1:0] qx, qy;
	logic [sgm_pkg::PIX_W-1:0] ax, ay;
	logic [sgm_pkg::PIX_W:0]   sum;

	always_comb begin
		gx = sx(taps.top) - sx(win_q[0]) + ((sx(taps.mid) - sx(win_q[1])) <<< 1)
			+ sx(taps.bot) - sx(win_q[2]);
		gy = sx(win_q[0]) + (sx(win_q[3]) <<< 1) + sx(taps.top)
			- sx(win_q[2]) - (sx(win_q[5]) <<< 1) - sx(taps.bot);
		// divide by 4 rounding toward zero
		qx = gx[SW-1] ? ((gx + SW'(3)) >>> 2) : (gx >>> 2);
		qy = gy[SW-1] ? ((gy + SW'(3)) >>> 2) : (gy >>> 2);
		ax = qx[SW-1] ? sgm_pkg::PIX_W'(-qx) : qx[sgm_pkg::PIX_W-1:0];
		ay = qy[SW-1] ? sgm_pkg::PIX_W'(-qy) : qy[sgm_pkg::PIX_W-1:0];
		sum = {1'b0, ax} + {1'b0, ay};
		magnitude = sum[sgm_pkg::PIX_W:1];
	end

endmodule

/* hw/rtl/sobel_gradient_magnitude_3x3_core.sv */
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude_3x3_core
// 3x3 Sobel gradient magnitude on a raster pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while in_stall is low and gives one result per
// clock for interior pixels while out_stall is low, registered in stage one
// and then the output register. Both previous rows sit in one line store
// RAM, {older, newer} per column: the entry is read when the pixel is taken
// and written back as it leaves stage one, where the registered read lands.
// Border pixels produce no transaction. Line store contents are undefined
// after reset and need no clearing pass; only a mid-frame width increase
// could read an unwritten entry.
module sobel_gradient_magnitude_3x3_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [sgm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sgm_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [sgm_pkg::PIX_W-1:0]       pixel,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [sgm_pkg::PIX_W-1:0]       magnitude,
	output logic [sgm_pkg::COL_W-1:0]       out_col,
	output logic [sgm_pkg::ROW_W-1:0]       out_row,
	output logic                            frame_last
);

	localparam int PW = sgm_pkg::PIX_W;
	localparam int CW = sgm_pkg::COL_W;
	localparam int RW = sgm_pkg::ROW_W;
	localparam int FW = sgm_pkg::CFG_W;

	logic [FW-1:0] frame_width_q, frame_height_q;
	logic [FW-1:0] w_eff, h_eff;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic          s1_valid_q;
	logic [PW-1:0] pix_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic          res_s1, last_s1;

	logic          in_acc, s1_adv, out_take;
	logic          row_end, frame_end;
	logic [2*PW-1:0] line_rd;
	sgm_pkg::taps_t  taps;
	logic [PW-1:0]   mag_s1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= sgm_pkg::RST_FRAME_WIDTH;
			frame_height_q <= sgm_pkg::RST_FRAME_HEIGHT;
		end else if (cfg_we) begin
			case (cfg_index)
				sgm_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data;
				sgm_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign w_eff = sgm_pkg::clamp_dim(frame_width_q, FW'(sgm_pkg::MAX_WIDTH));
	assign h_eff = sgm_pkg::clamp_dim(frame_height_q, FW'(sgm_pkg::MAX_HEIGHT));

	// handshake
	assign out_take = out_valid && !out_stall;
	assign s1_adv   = s1_valid_q && (!res_s1 || !out_valid || !out_stall);
	assign in_stall = s1_valid_q && !s1_adv;
	assign in_acc   = in_valid && !in_stall;

	assign row_end   = (FW'(col_q) + FW'(1)) >= w_eff;
	assign frame_end = row_end && ((FW'(row_q) + FW'(1)) >= h_eff);

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// stage one: line store data arrives
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_acc)
			s1_valid_q <= 1'b1;
		else if (s1_adv)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pixel;
			col_s1  <= col_q;
			row_s1  <= row_q;
			res_s1  <= (col_q >= CW'(2)) && (row_q >= RW'(2));
			last_s1 <= frame_end;
		end
	end

	// {older, newer}; read on accept, write back as the pixel leaves stage one
	sgm_ram #(
		.WIDTH(2 * PW),
		.DEPTH(sgm_pkg::MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (s1_adv),
		.waddr(col_s1),
		.wdata({line_rd[PW-1:0], pix_s1}),
		.re   (in_acc),
		.raddr(col_q),
		.rdata(line_rd)
	);

	assign taps.top = line_rd[2*PW-1:PW];
	assign taps.mid = line_rd[PW-1:0];
	assign taps.bot = pix_s1;

	sgm_window u_window (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift    (s1_adv),
		.taps     (taps),
		.magnitude(mag_s1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (s1_adv && res_s1)
			out_valid <= 1'b1;
		else if (out_take)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && res_s1) begin
			magnitude  <= mag_s1;
			out_col    <= col_s1 - CW'(1);
			out_row    <= row_s1 - RW'(1);
			frame_last <= last_s1;
		end
	end

`include "sobel_gradient_magnitude_3x3_core_macros.svh"

	`SGM_ASSERT_NOW(a_stall_needs_s1, clk, arst_n, in_stall, s1_valid_q && res_s1 && out_valid)
	`SGM_ASSERT_NEXT(a_result_lands, clk, arst_n, s1_adv && res_s1, out_valid)
	`SGM_ASSERT_NOW(a_interior_only, clk, arst_n, out_valid, (out_col != '0) && (out_row != '0))

endmodule

/* bench/tb_sobel_gradient_magnitude_3x3_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sobel_gradient_magnitude_3x3_core
// Streams raster frames through the Sobel core and checks every gradient
// transaction against a cycle-free model of the window and line stores.
// A short table of hand-checked frames comes first, then sizes clamped to
// the maximum and narrowed mid-frame, a fixed frame under a long output
// hold-off, then random frame sizes, including mid-frame size changes,
// with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_sobel_gradient_magnitude_3x3_core;

	localparam int N_ITEMS = 750;

	typedef struct packed {
		logic [sgm_pkg::PIX_W-1:0] mag;
		logic [sgm_pkg::COL_W-1:0] col;
		logic [sgm_pkg::ROW_W-1:0] row;
		logic                      last;
	} grad_t;

	typedef enum bit {ROW_REG, ROW_PIX} row_kind_t;

	typedef struct {
		row_kind_t                     kind;
		logic [sgm_pkg::CFG_IDX_W-1:0] idx;
		logic [sgm_pkg::CFG_W-1:0]     data;
		logic [sgm_pkg::PIX_W-1:0]     pix;
		bit                            typed;
		grad_t                         res;
	} dir_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [sgm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [sgm_pkg::CFG_W-1:0]     cfg_data = '0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [sgm_pkg::PIX_W-1:0]     pixel = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [sgm_pkg::PIX_W-1:0]     magnitude;
	logic [sgm_pkg::COL_W-1:0]     out_col;
	logic [sgm_pkg::ROW_W-1:0]     out_row;
	logic                          frame_last;

	// model state
	bit [sgm_pkg::PIX_W-1:0] row_m2 [sgm_pkg::MAX_WIDTH];
	bit [sgm_pkg::PIX_W-1:0] row_m1 [sgm_pkg::MAX_WIDTH];
	bit [sgm_pkg::PIX_W-1:0] win [6];
	int unsigned    cur_col = 0;
	int unsigned    cur_row = 0;
	logic [sgm_pkg::CFG_W-1:0] width_reg = sgm_pkg::RST_FRAME_WIDTH;
	logic [sgm_pkg::CFG_W-1:0] height_reg = sgm_pkg::RST_FRAME_HEIGHT;

	grad_t grad_q [$];
	int    errors = 0;
	int    pixels_taken = 0;
	int    send_calm = 0;
	bit    hold_now = 1'b0;

	// two tiny 3x3 frames; width and height written below range
	dir_row_t directed_tab [20] = '{
		'{ROW_REG, sgm_pkg::REG_FRAME_WIDTH,  11'd0, 8'd0, 1'b0, '0},
		'{ROW_REG, sgm_pkg::REG_FRAME_HEIGHT, 11'd2, 8'd0, 1'b0, '0},
		// bright top rows, dark bottom row: pure vertical gradient
		'{ROW_PIX, '0, '0, 8'd255, 1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd255, 1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd255, 1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd255, 1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd255, 1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd255, 1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b1, '{8'd127, 10'd1, 10'd1, 1'b1}},
		// lone bottom-left value: both sums are -6/4, truncated to -1
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd6,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b0, '0},
		'{ROW_PIX, '0, '0, 8'd0,   1'b1, '{8'd1, 10'd1, 10'd1, 1'b1}}
	};

	sobel_gradient_magnitude_3x3_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pixel      (pixel),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.magnitude  (magnitude),
		.out_col    (out_col),
		.out_row    (out_row),
		.frame_last (frame_last)
	);

	always #6 clk = ~clk;

	function automatic int unsigned eff_dim(input logic [sgm_pkg::CFG_W-1:0] v,
		input int unsigned hi);
		if (v < 3)
			return 3;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic [sgm_pkg::PIX_W-1:0] rand_pix();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return sgm_pkg::PIX_W'($urandom_range(0, 255));
	endfunction

	// advance the window by one pixel; returns 1 when a gradient is due
	function automatic bit sobel_predict(input logic [sgm_pkg::PIX_W-1:0] p, output grad_t g);
		int unsigned w_eff, h_eff, c;
		bit [sgm_pkg::PIX_W-1:0] up2, up1;
		bit row_done, frame_done, hit;
		int tl, ml, bl, tm, bm, tr, mr, br, gx, gy;
		w_eff = eff_dim(width_reg, sgm_pkg::MAX_WIDTH);
		h_eff = eff_dim(height_reg, sgm_pkg::MAX_HEIGHT);
		c = cur_col % sgm_pkg::MAX_WIDTH;
		up2 = row_m2[c];
		up1 = row_m1[c];
		row_done = (cur_col + 1 >= w_eff);
		frame_done = row_done && (cur_row + 1 >= h_eff);
		hit = (cur_col >= 2) && (cur_row >= 2);
		g = '0;
		if (hit) begin
			tl = win[0]; ml = win[1]; bl = win[2];
			tm = win[3]; bm = win[5];
			tr = up2; mr = up1; br = p;
			gx = (-tl + tr - 2 * ml + 2 * mr - bl + br) / 4;
			gy = (tl + 2 * tm + tr - bl - 2 * bm - br) / 4;
			if (gx < 0)
				gx = -gx;
			if (gy < 0)
				gy = -gy;
			g.mag = sgm_pkg::PIX_W'((gx + gy) / 2);
			g.col = sgm_pkg::COL_W'(cur_col - 1);
			g.row = sgm_pkg::ROW_W'(cur_row - 1);
			g.last = frame_done;
		end
		row_m2[c] = up1;
		row_m1[c] = p;
		win[0] = win[3]; win[1] = win[4]; win[2] = win[5];
		win[3] = up2;    win[4] = up1;    win[5] = p;
		if (row_done) begin
			cur_col = 0;
			cur_row = frame_done ? 0 : cur_row + 1;
		end else begin
			cur_col++;
		end
		return hit;
	endfunction

	task automatic push_pixel(input logic [sgm_pkg::PIX_W-1:0] p, input bit typed,
		input grad_t res);
		int gap;
		int r;
		grad_t g;
		gap = 0;
		if (send_calm > 0) begin
			send_calm--;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 2)
				send_calm = $urandom_range(30, 150);
			else if (r < 30)
				gap = gap_len();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_taken++;
		if (sobel_predict(p, g) && !typed)
			grad_q.push_back(g);
		if (typed)
			grad_q.push_back(res);
	endtask

	task automatic feed(input int n);
		repeat (n) push_pixel(rand_pix(), 1'b0, '0);
	endtask

	task automatic finish_frame();
		while (cur_col != 0 || cur_row != 0)
			push_pixel(rand_pix(), 1'b0, '0);
	endtask

	// drain: all results back, then cover the pipeline of border pixels
	task automatic settle();
		in_valid <= 1'b0;
		while (grad_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sgm_pkg::CFG_IDX_W-1:0] idx,
		input logic [sgm_pkg::CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == sgm_pkg::REG_FRAME_WIDTH)
			width_reg = val;
		else
			height_reg = val;
	endtask

	// result checker
	always @(posedge clk) begin
		grad_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (grad_q.size() == 0) begin
				$error("unexpected transaction: magnitude %0d col %0d row %0d last %0b",
					magnitude, out_col, out_row, frame_last);
				errors++;
			end else begin
				want = grad_q.pop_front();
				if (magnitude !== want.mag) begin
					$error("magnitude: expected %0d, got %0d", want.mag, magnitude);
					errors++;
				end
				if (out_col !== want.col) begin
					$error("out_col: expected %0d, got %0d", want.col, out_col);
					errors++;
				end
				if (out_row !== want.row) begin
					$error("out_row: expected %0d, got %0d", want.row, out_row);
					errors++;
				end
				if (frame_last !== want.last) begin
					$error("frame_last: expected %0d, got %0d", want.last, frame_last);
					errors++;
				end
			end
		end
	end

	// receiver: random stalls, calm stretches, one long hold-off mid-frame
	initial begin
		int hold_left;
		int calm_left;
		bit long_done;
		int r;
		hold_left = 0;
		calm_left = 0;
		long_done = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!long_done && hold_now) begin
				long_done = 1'b1;
				hold_left = 300;
				out_stall <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
				r = $urandom_range(0, 99);
				if (r < 2)
					calm_left = $urandom_range(50, 300);
				else if (r < 25)
					hold_left = gap_len();
			end
		end
	end

	initial begin
		#50_000_000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		int n;
		logic [sgm_pkg::CFG_W-1:0] new_w, new_h;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_tab[i]) begin
			if (directed_tab[i].kind == ROW_REG) begin
				settle();
				write_reg(directed_tab[i].idx, directed_tab[i].data);
			end else begin
				push_pixel(directed_tab[i].pix, directed_tab[i].typed, directed_tab[i].res);
			end
		end

		// both sizes clamped down to the maximum, then narrowed mid-row
		settle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 11'd2047);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 11'd2047);
		feed(40);
		settle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 11'd5);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 11'd6);
		finish_frame();

		// tall frame cut short once the row count is past the new height
		settle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 11'd3);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 11'd2047);
		feed(36);
		settle();
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 11'd8);
		finish_frame();

		// full frame with the receiver holding off from the middle on
		settle();
		write_reg(sgm_pkg::REG_FRAME_WIDTH, 11'd16);
		write_reg(sgm_pkg::REG_FRAME_HEIGHT, 11'd10);
		feed(48);
		hold_now = 1'b1;
		feed(112);

		// random sizes; a phase may stop mid-frame, so the next write lands mid-frame
		while (pixels_taken < N_ITEMS) begin
			new_w = sgm_pkg::CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
				($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(3, 12));
			new_h = sgm_pkg::CFG_W'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) :
				$urandom_range(3, 8));
			// widening mid-frame would read line entries never written
			if (eff_dim(new_w, sgm_pkg::MAX_WIDTH) > eff_dim(width_reg, sgm_pkg::MAX_WIDTH))
				finish_frame();
			settle();
			write_reg(sgm_pkg::REG_FRAME_WIDTH, new_w);
			write_reg(sgm_pkg::REG_FRAME_HEIGHT, new_h);
			n = $urandom_range(1, 2 * eff_dim(new_w, sgm_pkg::MAX_WIDTH) *
				eff_dim(new_h, sgm_pkg::MAX_HEIGHT));
			if (pixels_taken + n > N_ITEMS)
				n = (pixels_taken < N_ITEMS) ? N_ITEMS - pixels_taken : 0;
			feed(n);
		end

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
